### hdl/ucd_pkg.sv
// ----------------------------------------------------------------------------
// Undirected cycle detection package
// Shared constants and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ucd_pkg;

   // Fixed field widths of the stream payload and the vertex count register.
   localparam int RowIdxW          = 5;
   localparam int RowWidth         = 32;
   localparam int CountW           = 6;
   localparam int ReqDataW         = 40;
   localparam int RspDataW         = 8;
   localparam int ResetVertexCount = 32;

   // Commands from the controller to the datapath, one strobe each.
   typedef struct packed {
      logic row_write;
      logic search_start;
      logic root_push;
      logic root_next;
      logic scan_next;
      logic child_push;
      logic frame_pop;
      logic frame_restore;
   } ucd_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic root_done;
      logic root_visited;
      logic level_zero;
      logic scan_end;
      logic nb_push;
      logic nb_cycle;
   } ucd_stat_type;

endpackage

### hdl/ucd_datapath.sv
// ----------------------------------------------------------------------------
// Undirected cycle detection datapath
// Holds the adjacency memory, visited marks, search stack and current frame,
// and tests one neighbor of the current vertex per cycle while scanning.
// ----------------------------------------------------------------------------
module ucd_datapath
   import ucd_pkg::*;
#(
   parameter int MAX_VERTICES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CountW-1:0]    csr_wdata,
   input  logic [RowIdxW-1:0]   wr_index,
   input  logic [RowWidth-1:0]  wr_bits,
   input  ucd_cmd_type          cmd,
   output ucd_stat_type         stat
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef struct packed {
      logic [VW-1:0] vertex;
      logic [VW-1:0] parent;
      logic          has_parent;
      logic [CW-1:0] next;
   } frame_type;

   logic [CountW-1:0]       vertex_count_ff;
   logic [CW-1:0]           n_eff;
   logic [RowWidth-1:0]     row_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [RowWidth-1:0]     row_q_ff;
   logic [VW-1:0]           rd_addr;
   frame_type               stack_mem [MAX_VERTICES];
   frame_type               stack_q_ff;
   frame_type               cur_ff;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [CW-1:0]           root_ff;
   logic [CW-1:0]           level_ff;
   logic [CW-1:0]           level_dec;
   logic [VW-1:0]           scan_v;
   logic [VW-1:0]           root_v;
   logic [7:0]              scan_ext;
   logic                    edge_bit;
   logic                    nb_visited;

   // Vertex count register; counts above the storage depth are clamped.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= CountW'(ResetVertexCount);
      end else if (csr_we) begin
         vertex_count_ff <= csr_wdata;
      end
   end

   assign n_eff = (int'(vertex_count_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                          : CW'(vertex_count_ff);

   // Row read address follows the vertex that becomes current.
   always_comb begin
      rd_addr = cur_ff.vertex;
      if (cmd.root_push) begin
         rd_addr = root_v;
      end else if (cmd.child_push) begin
         rd_addr = scan_v;
      end else if (cmd.frame_restore) begin
         rd_addr = stack_q_ff.vertex;
      end
   end

   // Adjacency memory: written by row transfers, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.row_write && int'(wr_index) < MAX_VERTICES) begin
         row_mem[VW'(wr_index)] <= wr_bits;
      end
      row_q_ff <= row_valid_ff[rd_addr] ? row_mem[rd_addr] : '0;
   end

   // Rows that were never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.row_write && int'(wr_index) < MAX_VERTICES) begin
         row_valid_ff[VW'(wr_index)] <= 1'b1;
      end
   end

   // Neighbor test on the registered row of the current vertex.
   assign scan_v     = cur_ff.next[VW-1:0];
   assign root_v     = root_ff[VW-1:0];
   assign scan_ext   = 8'(cur_ff.next);
   assign edge_bit   = (scan_ext < 8'(RowWidth)) ? row_q_ff[scan_ext[RowIdxW-1:0]] : 1'b0;
   assign nb_visited = visited_ff[scan_v];
   assign level_dec  = level_ff - 1'b1;

   assign stat.root_done    = (root_ff >= n_eff);
   assign stat.root_visited = visited_ff[root_v];
   assign stat.level_zero   = (level_ff == '0);
   assign stat.scan_end     = (cur_ff.next >= n_eff);
   assign stat.nb_push      = edge_bit && !nb_visited;
   assign stat.nb_cycle     = edge_bit && nb_visited &&
                              (!cur_ff.has_parent || scan_v != cur_ff.parent);

   // Search control state: visited marks, root counter and stack level.
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         root_ff    <= '0;
         level_ff   <= '0;
      end else if (cmd.search_start) begin
         visited_ff <= '0;
         root_ff    <= '0;
         level_ff   <= '0;
      end else begin
         if (cmd.root_push) begin
            visited_ff[root_v] <= 1'b1;
         end
         if (cmd.root_next) begin
            root_ff <= root_ff + 1'b1;
         end
         if (cmd.child_push) begin
            visited_ff[scan_v] <= 1'b1;
            level_ff           <= level_ff + 1'b1;
         end
         if (cmd.frame_pop) begin
            level_ff <= level_dec;
         end
      end
   end

   // Current frame and the stack of suspended ancestor frames.
   always_ff @(posedge clock) begin
      if (cmd.root_push) begin
         cur_ff.vertex     <= root_v;
         cur_ff.parent     <= '0;
         cur_ff.has_parent <= 1'b0;
         cur_ff.next       <= '0;
      end else if (cmd.child_push) begin
         stack_mem[level_ff[VW-1:0]] <= '{vertex:     cur_ff.vertex,
                                          parent:     cur_ff.parent,
                                          has_parent: cur_ff.has_parent,
                                          next:       cur_ff.next + 1'b1};
         cur_ff.vertex     <= scan_v;
         cur_ff.parent     <= cur_ff.vertex;
         cur_ff.has_parent <= 1'b1;
         cur_ff.next       <= '0;
      end else if (cmd.scan_next) begin
         cur_ff.next <= cur_ff.next + 1'b1;
      end else if (cmd.frame_restore) begin
         cur_ff <= stack_q_ff;
      end
      if (cmd.frame_pop) begin
         stack_q_ff <= stack_mem[level_dec[VW-1:0]];
      end
   end

   // The stack depth is bounded by the number of distinct vertices.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      cmd.child_push |-> int'(level_ff) < MAX_VERTICES)
      else $error("search stack overflow");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      cmd.frame_pop |-> level_ff != '0)
      else $error("search stack underflow");

   // A new tree always starts on an empty stack.
   a_root_empty : assert property (@(posedge clock) disable iff (reset)
      cmd.root_push |-> level_ff == '0)
      else $error("root pushed onto a non-empty stack");

   // A descended-to vertex is marked visited by the time it is current.
   a_child_marked : assert property (@(posedge clock) disable iff (reset)
      cmd.child_push |=> visited_ff[cur_ff.vertex])
      else $error("current vertex not marked visited");

endmodule

### hdl/ucd_controller.sv
// ----------------------------------------------------------------------------
// Undirected cycle detection controller
// Sequences row loading, the depth-first search and the result transfer.
// ----------------------------------------------------------------------------
module ucd_controller
   import ucd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,
   output ucd_cmd_type         cmd,
   input  ucd_stat_type        stat
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ROOT    = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_RESTORE = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      found_ff, found_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff, rsp_found_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Search sequencer.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      found_in = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.row_write = 1'b1;
               if (req_tlast) begin
                  cmd.search_start = 1'b1;
                  state_in         = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (stat.root_done) begin
               found_in = 1'b0;
               state_in = ST_DONE;
            end else if (stat.root_visited) begin
               cmd.root_next = 1'b1;
            end else begin
               cmd.root_push = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_end) begin
               if (stat.level_zero) begin
                  cmd.root_next = 1'b1;
                  state_in      = ST_ROOT;
               end else begin
                  cmd.frame_pop = 1'b1;
                  state_in      = ST_RESTORE;
               end
            end else if (stat.nb_push) begin
               cmd.child_push = 1'b1;
            end else if (stat.nb_cycle) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_RESTORE: begin
            cmd.frame_restore = 1'b1;
            state_in          = ST_SCAN;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: loaded when the search ends and the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataW'(rsp_found_ff);

endmodule

### hdl/undirected_cycle_detect_core.sv
// ----------------------------------------------------------------------------
// Undirected cycle detection core
// Loads an adjacency matrix row by row and reports whether the graph holds
// a cycle, found by an iterative depth-first search.
// ----------------------------------------------------------------------------
// Row transfers are taken only while the core is idle. The transfer marked last
// stores its row and starts the search, during which no rows are taken. The
// datapath tests one neighbor of the current vertex per cycle against a
// registered row read, pausing while a parent frame is restored; each return
// to a parent frame passes through a pop and a restore step, and the search
// ends early when a cycle shows up. One result transfer follows each last row;
// it may wait in the output register while new rows are loaded. Rows and the
// vertex count persist between searches.
module undirected_cycle_detect_core
   import ucd_pkg::*;
#(
   parameter int MAX_VERTICES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // row_index[4:0], row_bits[36:5], zero fill
   input  logic                req_tlast,   // last_row
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // cycle_found[0], zero fill
   input  logic                csr_we,
   input  logic [CountW-1:0]   csr_wdata    // vertex_count
);

   ucd_cmd_type  cmd;
   ucd_stat_type stat;

   ucd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   ucd_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .wr_index  (req_tdata[RowIdxW-1:0]),
      .wr_bits   (req_tdata[RowIdxW+RowWidth-1:RowIdxW]),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

### test/undirected_cycle_detect_core_tb.sv
// ----------------------------------------------------------------------------
// Undirected cycle detection core testbench
// Loads adjacency rows over the request stream, predicts the outcome of each
// depth-first search with a behavioral copy of the search, and compares every
// response transfer against it. Directed corner graphs come first, followed
// by randomly built forests, cyclic graphs and noise rows under random idling
// on both streams and several vertex counts.
// ----------------------------------------------------------------------------
module undirected_cycle_detect_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ucd_pkg::*;

   localparam int NumVertices  = 32;
   localparam int MaxIdle      = 19;
   localparam int RandomRows   = 400;
   localparam int SettleCycles = 4;
   localparam int DrainCycles  = 1200;
   localparam int QuietLimit   = 20000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;   // row_index[4:0], row_bits[36:5], zero fill
   logic                req_tlast  = 1'b0; // last_row
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;         // cycle_found[0], zero fill
   logic                csr_we     = 1'b0;
   logic [CountW-1:0]   csr_wdata  = '0;   // vertex_count

   // Shadow copy of the block state used for prediction.
   logic [RowWidth-1:0] row_shadow [NumVertices];
   logic [CountW-1:0]   count_shadow;
   bit                  cycle_expect_q [$];

   int mismatches     = 0;
   int rows_sent      = 0;
   int ready_hold     = 0;
   bit send_gaps_on   = 1'b1;
   bit recv_stalls_on = 1'b1;

   undirected_cycle_detect_core #(
      .MAX_VERTICES(NumVertices)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Number of idle cycles for one transfer on either stream.
   function automatic int draw_idle(input bit enabled);
      return enabled ? $urandom_range(0, MaxIdle) : 0;
   endfunction

   // Iterative depth-first search over the shadow rows, roots and neighbors
   // taken in ascending order. A visited neighbor other than the parent is a
   // cycle; roots have no parent, so a root's self-loop counts too.
   function automatic bit predict_cycle();
      int                     n;
      int                     root;
      int                     depth;
      int                     t;
      int                     vtx;
      int                     nb;
      int                     frame_vertex [NumVertices];
      int                     frame_parent [NumVertices];
      int                     frame_next   [NumVertices];
      bit                     frame_root   [NumVertices];
      logic [NumVertices-1:0] seen;
      bit                     descended;
      n    = (count_shadow > NumVertices) ? NumVertices : int'(count_shadow);
      seen = '0;
      for (root = 0; root < n; root++) begin
         if (seen[root])
            continue;
         frame_vertex[0] = root;
         frame_parent[0] = 0;
         frame_next[0]   = 0;
         frame_root[0]   = 1'b1;
         seen[root]      = 1'b1;
         depth           = 1;
         while (depth > 0) begin
            t         = depth - 1;
            vtx       = frame_vertex[t];
            descended = 1'b0;
            for (nb = frame_next[t]; nb < n; nb++) begin
               if (!row_shadow[vtx][nb])
                  continue;
               if (!seen[nb]) begin
                  frame_next[t]       = nb + 1;
                  frame_vertex[depth] = nb;
                  frame_parent[depth] = vtx;
                  frame_next[depth]   = 0;
                  frame_root[depth]   = 1'b0;
                  seen[nb]            = 1'b1;
                  depth++;
                  descended = 1'b1;
                  break;
               end
               if (frame_root[t] || nb != frame_parent[t])
                  return 1'b1;
            end
            if (!descended)
               depth--;
         end
      end
      return 1'b0;
   endfunction

   // One row transfer; a last row also queues the predicted search outcome.
   task automatic send_row(input logic [RowIdxW-1:0] idx, input logic [RowWidth-1:0] bits,
                           input bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataW - RowIdxW - RowWidth){1'b0}}, bits, idx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      row_shadow[idx] = bits;
      rows_sent++;
      if (last)
         cycle_expect_q.push_back(predict_cycle());
      gap = draw_idle(send_gaps_on);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the request stream until every pending search has reported.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (cycle_expect_q.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [CountW-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we       <= 1'b0;
      count_shadow = value;
   endtask

   // Full-width rows, the reset count, a zero count and a count above the
   // storage size.
   task automatic test_directed_full_width();
      send_row(5'd31, '1, 1'b1);
      send_row(5'd31, '0, 1'b1);
      send_row(5'd0, 32'h0000_0001, 1'b1);
      wait_for_results();
      write_vertex_count(6'd0);
      send_row(5'd31, '1, 1'b1);
      send_row(5'd0, 32'h0000_0001, 1'b1);
      wait_for_results();
      write_vertex_count(6'd63);
      send_row(5'd5, 32'h0000_0020, 1'b0);
      send_row(5'd0, 32'hFFFF_FFF0, 1'b1);
   endtask

   // Small graphs: a path, a triangle, one-way edges, a self-loop beyond the
   // vertex count and neighbor bits above the count.
   task automatic test_directed_small_graphs();
      wait_for_results();
      write_vertex_count(6'd4);
      send_row(5'd2, 32'h0000_0000, 1'b0);
      send_row(5'd3, 32'h0000_0000, 1'b0);
      send_row(5'd0, 32'h0000_0002, 1'b0);
      send_row(5'd1, 32'h0000_0001, 1'b1);
      send_row(5'd5, 32'h0000_0020, 1'b1);
      send_row(5'd1, 32'h0000_0005, 1'b0);
      send_row(5'd2, 32'h0000_0003, 1'b0);
      send_row(5'd0, 32'h0000_0006, 1'b1);
      send_row(5'd0, 32'h0000_0000, 1'b0);
      send_row(5'd1, 32'h0000_0000, 1'b0);
      send_row(5'd2, 32'h0000_0008, 1'b1);
      send_row(5'd3, 32'h0000_0004, 1'b1);
      send_row(5'd2, 32'h0000_0000, 1'b1);
      send_row(5'd3, 32'h0000_0000, 1'b0);
      send_row(5'd0, 32'hFFFF_FFF0, 1'b1);
      wait_for_results();
      write_vertex_count(6'd2);
      send_row(5'd1, 32'h0000_0001, 1'b0);
      send_row(5'd0, 32'h0000_0002, 1'b1);
   endtask

   // Build one graph over n vertices and stream its rows in random order.
   // Forests give no cycle; the other shapes mostly do. Rows at or above n
   // carry random noise, and the broken shape sends only part of the rows.
   task automatic send_graph(input int n, input int shape);
      logic [RowWidth-1:0] adj [NumVertices];
      logic [RowWidth-1:0] used_mask;
      int                  order [$];
      int                  v;
      int                  p;
      int                  j;
      int                  tmp;
      used_mask = (n >= NumVertices) ? '1 : ((32'h1 << n) - 1);
      foreach (adj[v])
         adj[v] = (v < n) ? '0 : $urandom;
      if (n > 0) begin
         if (shape <= 5) begin
            for (v = 1; v < n; v++) begin
               if ($urandom_range(0, 3) != 0) begin
                  p         = $urandom_range(0, v - 1);
                  adj[v][p] = 1'b1;
                  adj[p][v] = 1'b1;
               end
            end
            if (shape >= 4) begin
               v         = $urandom_range(0, n - 1);
               p         = $urandom_range(0, n - 1);
               adj[v][p] = 1'b1;
               adj[p][v] = 1'b1;
            end
         end else if (shape <= 7) begin
            tmp = $urandom_range(1, 6);
            for (v = 0; v < n; v++) begin
               for (p = v; p < n; p++) begin
                  if ($urandom_range(0, 15) < ((v == p) ? 1 : tmp)) begin
                     adj[v][p] = 1'b1;
                     adj[p][v] = 1'b1;
                  end
               end
            end
         end else begin
            for (v = 0; v < n; v++)
               adj[v] = $urandom;
         end
         // Bits above the vertex count are ignored, so fill them with noise.
         for (v = 0; v < n; v++)
            adj[v] = (adj[v] & used_mask) | ($urandom & ~used_mask);
      end
      for (v = 0; v < n; v++) begin
         if (shape != 9 || $urandom_range(0, 1) == 1)
            order.push_back(v);
      end
      repeat ($urandom_range(0, 2))
         order.push_back($urandom_range(0, NumVertices - 1));
      if (order.size() == 0)
         order.push_back($urandom_range(0, NumVertices - 1));
      for (j = order.size() - 1; j > 0; j--) begin
         p        = $urandom_range(0, j);
         tmp      = order[j];
         order[j] = order[p];
         order[p] = tmp;
      end
      for (j = 0; j < order.size(); j++)
         send_row(RowIdxW'(order[j]), adj[order[j]], j == order.size() - 1);
   endtask

   // Phases of random graphs, each under its own vertex count and idling mix.
   task automatic test_random_graphs();
      int first_row;
      int pick;
      int n;
      first_row = rows_sent;
      while (rows_sent < first_row + RandomRows) begin
         wait_for_results();
         pick = $urandom_range(0, 9);
         case (pick)
            0:       write_vertex_count(6'd0);
            1:       write_vertex_count(6'd32);
            2:       write_vertex_count(CountW'($urandom_range(33, 63)));
            default: write_vertex_count(CountW'($urandom_range(1, 8)));
         endcase
         send_gaps_on   = ($urandom_range(0, 3) != 0);
         recv_stalls_on = ($urandom_range(0, 3) != 0);
         n = (count_shadow > NumVertices) ? NumVertices : int'(count_shadow);
         repeat ($urandom_range(1, (n > 8) ? 2 : 6)) begin
            send_graph(n, $urandom_range(0, 9));
            // Now and then let the block drain before the next graph.
            if ($urandom_range(0, 7) == 0)
               wait_for_results();
         end
      end
   endtask

   // Response side: random stalls on tready and a check of every transfer.
   always @(posedge clock) begin : result_check
      bit expected;
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (cycle_expect_q.size() == 0) begin
            $error("cycle_found: no search pending, got %0b", rsp_tdata[0]);
            mismatches++;
         end else begin
            expected = cycle_expect_q.pop_front();
            if (rsp_tdata[0] !== expected) begin
               $error("cycle_found: expected %0b, got %0b", expected, rsp_tdata[0]);
               mismatches++;
            end
         end
         stall = draw_idle(recv_stalls_on);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            ready_hold <= stall;
         end
      end else if (!rsp_tready) begin
         if (ready_hold <= 1)
            rsp_tready <= 1'b1;
         else
            ready_hold <= ready_hold - 1;
      end
   end

   // Ends the run when no transfer has happened on either stream for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      foreach (row_shadow[i])
         row_shadow[i] = '0;
      count_shadow = CountW'(ResetVertexCount);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_full_width();
      test_directed_small_graphs();
      test_random_graphs();
      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
